// ----- design/modexp_pkg.sv -----
// Shared constants and types for the modular exponentiation block.
`timescale 1ns / 1ps

package modexp_pkg;

  // Operand width used for the key and the base.
  localparam int unsigned WIDTH = 64;
  // Port field widths, fixed by the item format.
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam int unsigned SUM_W = WIDTH + 2;

  localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(1);
  localparam logic [WIDTH-1:0] EXPONENT_RESET = WIDTH'(65537);

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } state_e;

endpackage

// ----- design/modular_exponentiation.sv -----
// Modular exponentiation by left-to-right square-and-multiply with a bit-serial modular multiplier.
`timescale 1ns / 1ps

// Steps: after accept the base is reduced mod m, then for each of the WIDTH exponent bits, from the top,
//   a squaring and, where that bit is set, a multiply; the multiplier takes one multiplier bit per cycle.
//   A modulus of zero skips these steps and goes straight to a zero result.
// Throughput: one item at a time, set by the single shift-and-add modular multiplier that
//   does the base reduction, every squaring and every multiply in turn; the next item is taken
//   only once the result has entered the output register, which waits while that register is full.
// Reset: modulus is 1, exponent is 65537, no item in flight and the output register empty.
module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [DATA_W-1:0]    s_axis_tdata_i,  // [63:0] base_value
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [DATA_W-1:0]    m_axis_tdata_o   // [63:0] power_result
);

  state_e state_q, state_d;

  logic [WIDTH-1:0] mod_q, exp_q;
  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] mcand_q, mcand_d;
  logic [WIDTH-1:0] mplier_q, mplier_d;
  logic [WIDTH-1:0] exp_sh_q, exp_sh_d;
  logic [CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0] exp_cnt_q, exp_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_data_q, out_data_d;

  logic             in_accept;
  logic             out_load;
  logic             mod_zero;
  logic             last_bit;
  logic [WIDTH-1:0] one_mod;
  logic [SUM_W-1:0] sum, mod1, mod2;
  logic [WIDTH-1:0] r_nxt;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready_i);
  assign mod_zero        = (mod_q == '0);
  assign one_mod         = (mod_q == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign last_bit        = (bit_cnt_q == '0);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DATA_W'(out_data_q);

  // One multiplier bit: r = 2r + bit*a, which stays below 3m, then one of three candidates.
  always_comb begin
    sum  = SUM_W'({r_q, 1'b0}) + SUM_W'(mplier_q[WIDTH-1] ? mcand_q : '0);
    mod1 = SUM_W'(mod_q);
    mod2 = SUM_W'({mod_q, 1'b0});
    if (sum >= mod2) begin
      r_nxt = WIDTH'(sum - mod2);
    end else if (sum >= mod1) begin
      r_nxt = WIDTH'(sum - mod1);
    end else begin
      r_nxt = WIDTH'(sum);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = mod_zero ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (last_bit) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (last_bit) begin
          if (exp_sh_q[WIDTH-1]) begin
            state_d = ST_MULT;
          end else if (exp_cnt_q == '0) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_MULT: begin
        if (last_bit) begin
          state_d = (exp_cnt_q == '0) ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    base_d    = base_q;
    acc_d     = acc_q;
    r_d       = r_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    exp_sh_d  = exp_sh_q;
    bit_cnt_d = bit_cnt_q;
    exp_cnt_d = exp_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          // Reduce the base first: (1 mod m) times base, scanned bit by bit.
          acc_d     = mod_zero ? '0 : one_mod;
          mcand_d   = one_mod;
          mplier_d  = s_axis_tdata_i[WIDTH-1:0];
          r_d       = '0;
          bit_cnt_d = CNT_W'(WIDTH - 1);
          exp_sh_d  = exp_q;
          exp_cnt_d = CNT_W'(WIDTH - 1);
        end
      end
      ST_REDUCE, ST_SQUARE, ST_MULT: begin
        r_d       = r_nxt;
        mplier_d  = {mplier_q[WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - CNT_W'(1);
        if (last_bit) begin
          r_d       = '0;
          bit_cnt_d = CNT_W'(WIDTH - 1);
          if (state_q == ST_REDUCE) begin
            base_d   = r_nxt;
            mcand_d  = acc_q;
            mplier_d = acc_q;
          end else begin
            acc_d = r_nxt;
            if ((state_q == ST_SQUARE) && exp_sh_q[WIDTH-1]) begin
              mcand_d  = base_q;
              mplier_d = r_nxt;
            end else begin
              // Move on to the next exponent bit with a squaring.
              mcand_d   = r_nxt;
              mplier_d  = r_nxt;
              exp_sh_d  = {exp_sh_q[WIDTH-2:0], 1'b0};
              exp_cnt_d = exp_cnt_q - CNT_W'(1);
            end
          end
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mod_q       <= MODULUS_RESET;
      exp_q       <= EXPONENT_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_MODULUS:  mod_q <= cfg_data_i[WIDTH-1:0];
          REG_EXPONENT: exp_q <= cfg_data_i[WIDTH-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    acc_q      <= acc_d;
    r_q        <= r_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    exp_sh_q   <= exp_sh_d;
    bit_cnt_q  <= bit_cnt_d;
    exp_cnt_q  <= exp_cnt_d;
    out_data_q <= out_data_d;
  end

  a_zero_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && mod_zero) |=> (state_q == ST_FINISH) && (acc_q == '0))
    else $error("zero modulus did not go straight to a zero result");

  a_bit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT) && !last_bit)
    |=> (state_q == $past(state_q)) && (bit_cnt_q == $past(bit_cnt_q) - CNT_W'(1)))
    else $error("multiplier bit count did not step down");

  a_mult_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQUARE && last_bit && exp_sh_q[WIDTH-1]) |=> (state_q == ST_MULT))
    else $error("set exponent bit was not followed by a multiply");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o && (out_data_q == $past(acc_q)) && (state_q == ST_IDLE))
    else $error("finished result was not placed in the output register");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the square-and-multiply modular exponentiation block.
`timescale 1ns / 1ps

module tb_top;
  import modexp_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [DATA_W-1:0]    s_axis_tdata_i;  // [63:0] base_value
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [DATA_W-1:0]    m_axis_tdata_o;  // [63:0] power_result

  // Key registers as the block should hold them.
  logic [WIDTH-1:0] key_modulus;
  logic [WIDTH-1:0] key_exponent;

  logic [DATA_W-1:0] pending_bases[$];
  logic [WIDTH-1:0]  expected_powers[$];

  int error_count;
  int bases_accepted;
  int powers_checked;
  int cfg_writes;
  int key_settings;

  // Flow control knobs, set by the stimulus only at rising edges; the hold-off count runs down at falling edges.
  bit source_idle_on;
  bit sink_idle_on;
  int hold_off_left;

  bit base_taken;
  int gap_left;
  bit result_taken;
  int stall_left;

  modular_exponentiation i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [WIDTH-1:0] mod_product(input logic [WIDTH-1:0] a,
                                                   input logic [WIDTH-1:0] b,
                                                   input logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] wide;
    wide = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
    wide = wide % {{WIDTH{1'b0}}, m};
    return wide[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] predict_power(input logic [WIDTH-1:0] base,
                                                     input logic [WIDTH-1:0] e,
                                                     input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] b;
    int i;
    // Without a modulus nothing can be reduced, and the block answers zero.
    if (m == '0) return '0;
    acc = (m == WIDTH'(1)) ? '0 : WIDTH'(1);
    b = base % m;
    for (i = WIDTH - 1; i >= 0; i--) begin
      acc = mod_product(acc, acc, m);
      if (e[i]) acc = mod_product(acc, b, m);
    end
    return acc;
  endfunction

  function automatic int pick_wait(input bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [WIDTH-1:0] pick_modulus();
    logic [WIDTH-1:0] m;
    case ($urandom_range(0, 4))
      0: m = WIDTH'({$urandom, $urandom}) | {1'b1, {(WIDTH-1){1'b0}}};
      1: m = WIDTH'({$urandom, $urandom}) >> $urandom_range(0, WIDTH - 1);
      2: m = WIDTH'($urandom_range(2, 1000));
      3: m = '1 - WIDTH'($urandom_range(0, 100));
      default: m = WIDTH'({$urandom, $urandom});
    endcase
    return m;
  endfunction

  function automatic logic [WIDTH-1:0] pick_exponent();
    logic [WIDTH-1:0] e;
    case ($urandom_range(0, 4))
      0: e = WIDTH'($urandom_range(0, 20));
      1: e = WIDTH'({$urandom, $urandom}) >> $urandom_range(0, WIDTH - 1);
      2: e = EXPONENT_RESET;
      default: e = WIDTH'({$urandom, $urandom});
    endcase
    return e;
  endfunction

  function automatic logic [DATA_W-1:0] pick_base(input logic [WIDTH-1:0] m);
    logic [DATA_W-1:0] b;
    case ($urandom_range(0, 9))
      0: b = '0;
      1: b = '1;
      2: b = DATA_W'(m);
      3: b = DATA_W'(m - WIDTH'(1));
      4: b = DATA_W'(m + WIDTH'($urandom_range(1, 50)));
      default: b = {$urandom, $urandom};
    endcase
    return b;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR: %s", $realtime, what);
    error_count++;
  endtask

  // Writes one key register; returns at a rising edge with the channel idle.
  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MODULUS) key_modulus = value[WIDTH-1:0];
    else if (idx == REG_EXPONENT) key_exponent = value[WIDTH-1:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_key(input logic [WIDTH-1:0] m, input logic [WIDTH-1:0] e);
    if ($urandom_range(0, 1)) begin
      write_key_reg(REG_MODULUS, DATA_W'(m));
      write_key_reg(REG_EXPONENT, DATA_W'(e));
    end else begin
      write_key_reg(REG_EXPONENT, DATA_W'(e));
      write_key_reg(REG_MODULUS, DATA_W'(m));
    end
    key_settings++;
  endtask

  // Sender pause: returns once every queued base has gone in and every result has come back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_bases.size() != 0 || s_axis_tvalid_i || expected_powers.size() != 0);
  endtask

  // Input side: records accepted bases and predicts their results.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_powers.push_back(predict_power(s_axis_tdata_i[WIDTH-1:0], key_exponent,
                                              key_modulus));
      bases_accepted++;
      base_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (base_taken) begin
        base_taken = 1'b0;
        gap_left   = pick_wait(source_idle_on);
        if (gap_left > 0) begin
          s_axis_tvalid_i <= 1'b0;
          gap_left--;
        end else if (pending_bases.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_bases.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end else if (!s_axis_tvalid_i) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bases.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_bases.pop_front();
        end
      end
    end
  end

  // Output side: checks each result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      result_taken = 1'b1;
      if (expected_powers.size() == 0) begin
        report_mismatch($sformatf("result %h with no base outstanding", m_axis_tdata_o));
      end else begin
        logic [WIDTH-1:0] want;
        want = expected_powers.pop_front();
        if (m_axis_tdata_o !== DATA_W'(want))
          report_mismatch($sformatf("power_result %h, expected %h (modulus %h exponent %h)",
                                    m_axis_tdata_o, want, key_modulus, key_exponent));
        powers_checked++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        stall_left   = pick_wait(sink_idle_on);
      end
      if (hold_off_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [WIDTH-1:0] m;
    int phase;
    int k;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    key_modulus     = MODULUS_RESET;
    key_exponent    = EXPONENT_RESET;
    source_idle_on  = 1'b1;
    sink_idle_on    = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // The reset key has a modulus of one, so everything reduces to zero.
    key_settings = 1;
    pending_bases.push_back('0);
    pending_bases.push_back('1);
    wait_drained();

    // Largest modulus with the usual public exponent, bases at the field extremes.
    set_key('1, EXPONENT_RESET);
    pending_bases.push_back('0);
    pending_bases.push_back(DATA_W'(1));
    pending_bases.push_back(DATA_W'(2));
    pending_bases.push_back('1 - DATA_W'(1));
    pending_bases.push_back('1);
    pending_bases.push_back({1'b1, {(DATA_W-1){1'b0}}});
    pending_bases.push_back({(DATA_W/2){2'b01}});
    pending_bases.push_back({(DATA_W/2){2'b10}});
    wait_drained();

    // A zero exponent always yields one.
    set_key('1 - WIDTH'(58), '0);
    pending_bases.push_back('0);
    pending_bases.push_back('1);
    pending_bases.push_back({$urandom, $urandom});
    wait_drained();

    // Modulus of one with the largest exponent.
    set_key(WIDTH'(1), '1);
    pending_bases.push_back({$urandom, $urandom});
    pending_bases.push_back('1);
    wait_drained();

    // Modulus of zero cannot reduce and answers zero at once.
    set_key('0, WIDTH'({$urandom, $urandom}));
    pending_bases.push_back('1);
    pending_bases.push_back({$urandom, $urandom});
    wait_drained();

    // Writes to unknown register indexes must leave the key alone.
    set_key(WIDTH'(97), '1);
    write_key_reg(CFG_IDX_W'(2), '0);
    write_key_reg('1, '1);
    pending_bases.push_back(DATA_W'(96));
    pending_bases.push_back(DATA_W'(97));
    pending_bases.push_back(DATA_W'(98));
    pending_bases.push_back('1);
    wait_drained();

    // An exponent of one returns the reduced base.
    set_key(WIDTH'({$urandom, $urandom}) | {1'b1, {(WIDTH-1){1'b0}}}, WIDTH'(1));
    pending_bases.push_back('1);
    pending_bases.push_back({$urandom, $urandom});
    wait_drained();

    for (phase = 0; phase < 10; phase++) begin
      source_idle_on = (phase % 3) != 1;
      sink_idle_on   = (phase % 4) != 2;
      if ($urandom_range(0, 3) == 0)
        write_key_reg(CFG_IDX_W'($urandom_range(2, 255)), {$urandom, $urandom});
      set_key(pick_modulus(), pick_exponent());
      m = key_modulus;
      for (k = 0; k < 8; k++) pending_bases.push_back(pick_base(m));
      // Keep the result side closed long enough for the block to back up its input.
      if (phase == 2) begin
        source_idle_on = 1'b0;
        hold_off_left  = 20000;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (expected_powers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_powers.size()));
    $display("Ran %0d bases through %0d key settings (%0d register writes).",
             bases_accepted, key_settings, cfg_writes);
    $display("Checked %0d results, %0d errors.", powers_checked, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", expected_powers.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/modexp_pkg.sv
design/modular_exponentiation.sv
verif/tb_top.sv
